FILE: src/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants for the Strassen-Winograd multiplier
// Item payloads, sequencer states, quadrant codes and the control and status
// groups passed between the top level and the multiply-accumulate unit.
// ---------------------------------------------------------------------------
package swm_pkg;

   localparam int ELEM_W  = 16;              // element width of A and B
   localparam int SUM_W   = ELEM_W + 3;      // Winograd sum of up to four elements
   localparam int PROD_W  = 2 * SUM_W;       // one sum by sum product
   localparam int C_W     = 48;              // result element width
   localparam int NPROD   = 7;               // quadrant products
   localparam int WORD_W  = NPROD * SUM_W;   // all seven sums of one position

   localparam logic [1:0] QD_11 = 2'd0;
   localparam logic [1:0] QD_12 = 2'd1;
   localparam logic [1:0] QD_21 = 2'd2;
   localparam logic [1:0] QD_22 = 2'd3;

   localparam logic [2:0] K_LAST = 3'd6;     // last product index

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_value;
      logic signed [ELEM_W-1:0] b_value;
   } req_type;

   typedef struct packed {
      logic signed [C_W-1:0] c_value;
      logic                  last_element;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUMS,
      ST_MULT,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_HOLD
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       first;     // first term of a dot product
      logic       x_end;     // last term of the last product of a position
      logic       all_end;   // last term of the whole multiply phase
      logic [2:0] k;         // product index
   } mac_ctl_type;

   typedef struct packed {
      logic done;            // result quadrants of one position are ready
      logic all_end;         // and it is the last position
   } mac_stat_type;

endpackage

FILE: src/swm_mac.sv
// ---------------------------------------------------------------------------
// swm_mac: shared multiply-accumulate unit
// Selects one Winograd sum pair, multiplies it, accumulates seven dot
// products per position and combines them into the four result quadrants.
// ---------------------------------------------------------------------------
module swm_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swm_pkg::mac_ctl_type                 ctl,
   input  logic [swm_pkg::WORD_W-1:0]           lft_word,
   input  logic [swm_pkg::WORD_W-1:0]           rgt_word,
   output swm_pkg::mac_stat_type                stat,
   output logic [3:0][swm_pkg::C_W-1:0]         c_quad
);

   logic signed [swm_pkg::SUM_W-1:0]  lft_sel;
   logic signed [swm_pkg::SUM_W-1:0]  rgt_sel;
   logic signed [swm_pkg::PROD_W-1:0] prod_ff;
   logic signed [swm_pkg::PROD_W-1:0] prod_in;
   swm_pkg::mac_ctl_type              ctl2_ff;
   swm_pkg::mac_ctl_type              ctl3_ff;
   logic signed [swm_pkg::C_W-1:0]    acc_ff [swm_pkg::NPROD];
   logic signed [swm_pkg::C_W-1:0]    acc_in;
   logic signed [swm_pkg::C_W-1:0]    prod_ext;
   logic signed [swm_pkg::C_W-1:0]    v1, v2, v3;

   // pick the sum pair of this product and multiply
   always_comb begin
      lft_sel = lft_word[ctl.k*swm_pkg::SUM_W +: swm_pkg::SUM_W];
      rgt_sel = rgt_word[ctl.k*swm_pkg::SUM_W +: swm_pkg::SUM_W];
      prod_in = lft_sel * rgt_sel;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // advance the control tags
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl2_ff <= ctl;
         ctl3_ff <= ctl2_ff;
      end
   end

   // accumulate into the slot of this product
   always_comb begin
      prod_ext = {{(swm_pkg::C_W-swm_pkg::PROD_W){prod_ff[swm_pkg::PROD_W-1]}}, prod_ff};
      acc_in   = ctl2_ff.first ? prod_ext : acc_ff[ctl2_ff.k] + prod_ext;
   end

   always_ff @(posedge clock) begin
      if (ctl2_ff.valid) begin
         acc_ff[ctl2_ff.k] <= acc_in;
      end
   end

   // combine the seven products into the result quadrants
   always_comb begin
      v1 = acc_ff[0] + acc_ff[1];
      v2 = v1 + acc_ff[3];
      v3 = acc_ff[4] + acc_ff[5];
      c_quad[swm_pkg::QD_11] = acc_ff[1] + acc_ff[2];
      c_quad[swm_pkg::QD_12] = v1 + v3;
      c_quad[swm_pkg::QD_21] = v2 - acc_ff[6];
      c_quad[swm_pkg::QD_22] = v2 + acc_ff[4];
      stat.done    = ctl3_ff.valid && ctl3_ff.x_end;
      stat.all_end = ctl3_ff.valid && ctl3_ff.all_end;
   end

   // a position ends only on the last product
   assert property (@(posedge clock) disable iff (reset)
      ctl.valid && ctl.x_end |-> ctl.k == swm_pkg::K_LAST)
      else $error("position ends before the last product");

   // the whole phase ends only at the end of a position
   assert property (@(posedge clock) disable iff (reset)
      ctl.valid && ctl.all_end |-> ctl.x_end)
      else $error("phase end without position end");

   // a done flag follows an issued last term through the ctl2 and ctl3 tag registers
   assert property (@(posedge clock) disable iff (reset)
      stat.done |-> $past(ctl.valid && ctl.x_end, 2))
      else $error("done flag without matching issue");

endmodule

FILE: src/strassen_winograd_matmul.sv
// ---------------------------------------------------------------------------
// strassen_winograd_matmul: one-level Strassen-Winograd matrix multiply
// Loads A and B element pairs, forms Winograd sums, seven quadrant products
// on one shared multiplier, and streams out C in row-major order.
// ---------------------------------------------------------------------------
// Usage: write csr_wdata (half the dimension m, clamped to 1..MAX_DIM/2) while
// idle; the dimension is n = 2m. Send n*n items of A and B in row-major order,
// one cycle each. Then the block stalls its input: the sum pass reads the four
// quadrant elements of each position, the multiply pass runs the single
// multiplier once per term, and the output pass steps through its read, load and
// hold states for each element of C, waiting in hold while rsp_stall is high.
// The last element of C carries last_element; input is taken again once it
// has been accepted. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module strassen_winograd_matmul #(
   parameter int MAX_DIM = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swm_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_wdata
);

   localparam int HALF = MAX_DIM / 2;
   localparam int QSZ  = HALF * HALF;
   localparam int FULL = MAX_DIM * MAX_DIM;
   localparam int HW   = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int XW   = (QSZ > 1) ? $clog2(QSZ) : 1;
   localparam int AW   = $clog2(FULL);
   localparam int CW   = $clog2(FULL + 1);
   localparam int MW   = $clog2(HALF + 1);

   // -------------------------------------------------------------------------
   // storage
   // -------------------------------------------------------------------------
   logic [swm_pkg::ELEM_W-1:0] a_mem   [FULL];
   logic [swm_pkg::ELEM_W-1:0] b_mem   [FULL];
   logic [swm_pkg::WORD_W-1:0] lft_mem [QSZ];
   logic [swm_pkg::WORD_W-1:0] rgt_mem [QSZ];
   logic [4*swm_pkg::C_W-1:0]  c_mem   [QSZ];

   logic signed [swm_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic [swm_pkg::WORD_W-1:0]        lft_rd_ff, rgt_rd_ff;
   logic [3:0][swm_pkg::C_W-1:0]      c_rd_ff;

   // -------------------------------------------------------------------------
   // control registers
   // -------------------------------------------------------------------------
   swm_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        load_count_ff, load_count_in;
   logic [2:0]           half_size_ff;
   logic [HW-1:0]        s_i_ff, s_i_in, s_j_ff, s_j_in;
   logic [1:0]           s_q_ff, s_q_in;
   logic                 s_fin_ff, s_fin_in;
   logic                 rd_v_ff, rd_v_in, rd_last_ff, rd_last_in;
   logic [1:0]           rd_q_ff, rd_q_in;
   logic [XW-1:0]        rd_x_ff, rd_x_in;
   logic [HW-1:0]        m_i_ff, m_i_in, m_j_ff, m_j_in, m_l_ff, m_l_in;
   logic [2:0]           m_k_ff, m_k_in;
   logic                 m_fin_ff, m_fin_in;
   swm_pkg::mac_ctl_type ctl1_ff, ctl1_in;
   logic [HW-1:0]        w_i_ff, w_i_in, w_j_ff, w_j_in;
   logic [HW-1:0]        o_i_ff, o_i_in, o_j_ff, o_j_in;
   logic                 o_qr_ff, o_qr_in, o_qc_ff, o_qc_in;
   swm_pkg::rsp_type     rsp_ff;

   logic signed [swm_pkg::ELEM_W-1:0] a11_ff, a12_ff, a21_ff, b11_ff, b12_ff, b21_ff;

   // -------------------------------------------------------------------------
   // active size
   // -------------------------------------------------------------------------
   logic [MW-1:0] m_act;
   logic [HW-1:0] m_lim;
   logic [CW-1:0] n_dim, total;

   always_comb begin
      priority if (half_size_ff == 3'd0) begin
         m_act = MW'(1);
      end else if (32'(half_size_ff) > HALF) begin
         m_act = MW'(HALF);
      end else begin
         m_act = MW'(half_size_ff);
      end
      m_lim = HW'(m_act - MW'(1));
      n_dim = CW'(m_act) << 1;
      total = CW'(n_dim * n_dim);
   end

   // -------------------------------------------------------------------------
   // addresses
   // -------------------------------------------------------------------------
   logic [AW-1:0] s_row, s_col, s_addr;
   logic [XW-1:0] s_x, lft_addr, rgt_addr, w_x, o_x;

   always_comb begin
      s_row    = AW'(s_q_ff[1] ? AW'(m_act) : AW'(0)) + AW'(s_i_ff);
      s_col    = AW'(s_q_ff[0] ? AW'(m_act) : AW'(0)) + AW'(s_j_ff);
      s_addr   = AW'(s_row * AW'(n_dim)) + s_col;
      s_x      = XW'(XW'(s_i_ff) * XW'(HALF)) + XW'(s_j_ff);
      lft_addr = XW'(XW'(m_i_ff) * XW'(HALF)) + XW'(m_l_ff);
      rgt_addr = XW'(XW'(m_l_ff) * XW'(HALF)) + XW'(m_j_ff);
      w_x      = XW'(XW'(w_i_ff) * XW'(HALF)) + XW'(w_j_ff);
      o_x      = XW'(XW'(o_i_ff) * XW'(HALF)) + XW'(o_j_ff);
   end

   // -------------------------------------------------------------------------
   // Winograd sums of one position
   // -------------------------------------------------------------------------
   logic signed [swm_pkg::SUM_W-1:0] a11, a12, a21, a22, b11, b12, b21, b22;
   logic signed [swm_pkg::SUM_W-1:0] s1, s2, s3, s4, t1, t2, t3, t4;
   logic [swm_pkg::WORD_W-1:0]       lft_word, rgt_word;

   always_comb begin
      a11 = swm_pkg::SUM_W'(a11_ff);
      a12 = swm_pkg::SUM_W'(a12_ff);
      a21 = swm_pkg::SUM_W'(a21_ff);
      a22 = swm_pkg::SUM_W'(a_rd_ff);
      b11 = swm_pkg::SUM_W'(b11_ff);
      b12 = swm_pkg::SUM_W'(b12_ff);
      b21 = swm_pkg::SUM_W'(b21_ff);
      b22 = swm_pkg::SUM_W'(b_rd_ff);
      s1 = a21 + a22;
      s2 = s1 - a11;
      s3 = a11 - a21;
      s4 = a12 - s2;
      t1 = b12 - b11;
      t2 = b22 - t1;
      t3 = b22 - b12;
      t4 = t2 - b21;
      lft_word = {a22, s4, s1, s3, a12, a11, s2};
      rgt_word = {t4, b22, t1, t3, b21, b11, t2};
   end

   // -------------------------------------------------------------------------
   // multiply-accumulate unit
   // -------------------------------------------------------------------------
   swm_pkg::mac_stat_type        mac_stat;
   logic [3:0][swm_pkg::C_W-1:0] c_quad;

   swm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl1_ff),
      .lft_word (lft_rd_ff),
      .rgt_word (rgt_rd_ff),
      .stat     (mac_stat),
      .c_quad   (c_quad)
   );

   // -------------------------------------------------------------------------
   // memories
   // -------------------------------------------------------------------------
   logic req_take;
   logic sum_wr;

   always_comb begin
      req_take = req_valid && !req_stall;
      sum_wr   = rd_v_ff && (rd_q_ff == swm_pkg::QD_22);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_mem[load_count_ff[AW-1:0]] <= req_data.a_value;
         b_mem[load_count_ff[AW-1:0]] <= req_data.b_value;
      end
      a_rd_ff <= a_mem[s_addr];
      b_rd_ff <= b_mem[s_addr];
   end

   always_ff @(posedge clock) begin
      if (sum_wr) begin
         lft_mem[rd_x_ff] <= lft_word;
         rgt_mem[rd_x_ff] <= rgt_word;
      end
      lft_rd_ff <= lft_mem[lft_addr];
      rgt_rd_ff <= rgt_mem[rgt_addr];
   end

   always_ff @(posedge clock) begin
      if (mac_stat.done) begin
         c_mem[w_x] <= c_quad;
      end
      c_rd_ff <= c_mem[o_x];
   end

   // hold the first three quadrant elements of a position
   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         unique case (rd_q_ff)
            swm_pkg::QD_11: begin
               a11_ff <= a_rd_ff;
               b11_ff <= b_rd_ff;
            end
            swm_pkg::QD_12: begin
               a12_ff <= a_rd_ff;
               b12_ff <= b_rd_ff;
            end
            swm_pkg::QD_21: begin
               a21_ff <= a_rd_ff;
               b21_ff <= b_rd_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   logic o_last;

   always_comb begin
      o_last = o_qr_ff && o_qc_ff && (o_i_ff == m_lim) && (o_j_ff == m_lim);
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      s_i_in        = s_i_ff;
      s_j_in        = s_j_ff;
      s_q_in        = s_q_ff;
      s_fin_in      = s_fin_ff;
      rd_v_in       = 1'b0;
      rd_q_in       = s_q_ff;
      rd_x_in       = s_x;
      rd_last_in    = 1'b0;
      m_i_in        = m_i_ff;
      m_j_in        = m_j_ff;
      m_k_in        = m_k_ff;
      m_l_in        = m_l_ff;
      m_fin_in      = m_fin_ff;
      ctl1_in       = '0;
      w_i_in        = w_i_ff;
      w_j_in        = w_j_ff;
      o_i_in        = o_i_ff;
      o_j_in        = o_j_ff;
      o_qr_in       = o_qr_ff;
      o_qc_in       = o_qc_ff;

      unique case (state_ff)
         swm_pkg::ST_LOAD: begin
            if (req_take) begin
               if (load_count_ff == total - CW'(1)) begin
                  load_count_in = '0;
                  state_in      = swm_pkg::ST_SUMS;
                  s_i_in        = '0;
                  s_j_in        = '0;
                  s_q_in        = swm_pkg::QD_11;
                  s_fin_in      = 1'b0;
               end else begin
                  load_count_in = load_count_ff + CW'(1);
               end
            end
         end

         swm_pkg::ST_SUMS: begin
            // issue one quadrant read per cycle
            if (!s_fin_ff) begin
               rd_v_in = 1'b1;
               s_q_in  = s_q_ff + 2'd1;
               if (s_q_ff == swm_pkg::QD_22) begin
                  if (s_j_ff == m_lim) begin
                     s_j_in = '0;
                     if (s_i_ff == m_lim) begin
                        s_fin_in   = 1'b1;
                        rd_last_in = 1'b1;
                     end else begin
                        s_i_in = s_i_ff + HW'(1);
                     end
                  end else begin
                     s_j_in = s_j_ff + HW'(1);
                  end
               end
            end
            // move on once the last sums are written
            if (sum_wr && rd_last_ff) begin
               state_in = swm_pkg::ST_MULT;
               m_i_in   = '0;
               m_j_in   = '0;
               m_k_in   = '0;
               m_l_in   = '0;
               m_fin_in = 1'b0;
               w_i_in   = '0;
               w_j_in   = '0;
            end
         end

         swm_pkg::ST_MULT: begin
            // issue one product term per cycle
            if (!m_fin_ff) begin
               ctl1_in.valid   = 1'b1;
               ctl1_in.first   = (m_l_ff == '0);
               ctl1_in.k       = m_k_ff;
               ctl1_in.x_end   = (m_l_ff == m_lim) && (m_k_ff == swm_pkg::K_LAST);
               ctl1_in.all_end = ctl1_in.x_end && (m_i_ff == m_lim) && (m_j_ff == m_lim);
               if (m_l_ff == m_lim) begin
                  m_l_in = '0;
                  if (m_k_ff == swm_pkg::K_LAST) begin
                     m_k_in = '0;
                     if (m_j_ff == m_lim) begin
                        m_j_in = '0;
                        if (m_i_ff == m_lim) begin
                           m_fin_in = 1'b1;
                        end else begin
                           m_i_in = m_i_ff + HW'(1);
                        end
                     end else begin
                        m_j_in = m_j_ff + HW'(1);
                     end
                  end else begin
                     m_k_in = m_k_ff + 3'd1;
                  end
               end else begin
                  m_l_in = m_l_ff + HW'(1);
               end
            end
            // advance the result write position
            if (mac_stat.done) begin
               if (w_j_ff == m_lim) begin
                  w_j_in = '0;
                  w_i_in = w_i_ff + HW'(1);
               end else begin
                  w_j_in = w_j_ff + HW'(1);
               end
            end
            if (mac_stat.all_end) begin
               state_in = swm_pkg::ST_OUT_RD;
               o_i_in   = '0;
               o_j_in   = '0;
               o_qr_in  = 1'b0;
               o_qc_in  = 1'b0;
            end
         end

         swm_pkg::ST_OUT_RD: begin
            state_in = swm_pkg::ST_OUT_LD;
         end

         swm_pkg::ST_OUT_LD: begin
            state_in = swm_pkg::ST_OUT_HOLD;
         end

         swm_pkg::ST_OUT_HOLD: begin
            // step through C in row-major order
            if (!rsp_stall) begin
               if (o_last) begin
                  state_in = swm_pkg::ST_LOAD;
               end else begin
                  state_in = swm_pkg::ST_OUT_RD;
                  if (o_j_ff == m_lim) begin
                     o_j_in = '0;
                     if (o_qc_ff) begin
                        o_qc_in = 1'b0;
                        if (o_i_ff == m_lim) begin
                           o_i_in  = '0;
                           o_qr_in = 1'b1;
                        end else begin
                           o_i_in = o_i_ff + HW'(1);
                        end
                     end else begin
                        o_qc_in = 1'b1;
                     end
                  end else begin
                     o_j_in = o_j_ff + HW'(1);
                  end
               end
            end
         end

         default: begin
            state_in = swm_pkg::ST_LOAD;
         end
      endcase

      // a size write drops a partly loaded matrix
      if (csr_we) begin
         load_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= swm_pkg::ST_LOAD;
         load_count_ff <= '0;
         half_size_ff  <= 3'd4;
         s_i_ff        <= '0;
         s_j_ff        <= '0;
         s_q_ff        <= '0;
         s_fin_ff      <= 1'b1;
         rd_v_ff       <= 1'b0;
         rd_q_ff       <= '0;
         rd_x_ff       <= '0;
         rd_last_ff    <= 1'b0;
         m_i_ff        <= '0;
         m_j_ff        <= '0;
         m_k_ff        <= '0;
         m_l_ff        <= '0;
         m_fin_ff      <= 1'b1;
         ctl1_ff       <= '0;
         w_i_ff        <= '0;
         w_j_ff        <= '0;
         o_i_ff        <= '0;
         o_j_ff        <= '0;
         o_qr_ff       <= 1'b0;
         o_qc_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         if (csr_we) begin
            half_size_ff <= csr_wdata;
         end
         s_i_ff        <= s_i_in;
         s_j_ff        <= s_j_in;
         s_q_ff        <= s_q_in;
         s_fin_ff      <= s_fin_in;
         rd_v_ff       <= rd_v_in;
         rd_q_ff       <= rd_q_in;
         rd_x_ff       <= rd_x_in;
         rd_last_ff    <= rd_last_in;
         m_i_ff        <= m_i_in;
         m_j_ff        <= m_j_in;
         m_k_ff        <= m_k_in;
         m_l_ff        <= m_l_in;
         m_fin_ff      <= m_fin_in;
         ctl1_ff       <= ctl1_in;
         w_i_ff        <= w_i_in;
         w_j_ff        <= w_j_in;
         o_i_ff        <= o_i_in;
         o_j_ff        <= o_j_in;
         o_qr_ff       <= o_qr_in;
         o_qc_ff       <= o_qc_in;
      end
   end

   // load the output register from the chosen quadrant
   always_ff @(posedge clock) begin
      if (state_ff == swm_pkg::ST_OUT_LD) begin
         rsp_ff.c_value      <= c_rd_ff[{o_qr_ff, o_qc_ff}];
         rsp_ff.last_element <= o_last;
      end
   end

   assign req_stall = (state_ff != swm_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == swm_pkg::ST_OUT_HOLD);
   assign rsp_data  = rsp_ff;

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   // the load count never reaches a full matrix
   assert property (@(posedge clock) disable iff (reset)
      load_count_ff < total)
      else $error("load count past the matrix size");

   // input and output are never open together
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("input open while an item is shown");

   // after the last element the block takes input again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_element |=> !req_stall)
      else $error("no return to loading after the last element");

   // products complete only during the multiply phase
   assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> state_ff == swm_pkg::ST_MULT)
      else $error("product completion outside the multiply phase");

endmodule

FILE: verif/tb_strassen_winograd_matmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_strassen_winograd_matmul: self-checking bench for the matrix multiplier
// Loads A and B pairs at several half sizes (including the clamped ones and a
// discarded partial load) and checks every element of C and its last flag
// against a direct row-by-column product, under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_strassen_winograd_matmul;

   localparam int CLK_HALF   = 6;
   localparam int HALF_MAX   = 4;
   localparam int CYCLE_CAP  = 600000;
   localparam int LONG_HOLD  = 2000;
   localparam int RAND_ITEMS = 50;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   swm_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   swm_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [2:0]       csr_wdata;

   strassen_winograd_matmul dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // pending input items and expected elements of C
   swm_pkg::req_type pending_pairs[$];
   swm_pkg::rsp_type expected_elems[$];

   // predictor state
   logic [2:0]                        half_reg;
   int                                pairs_loaded;
   logic signed [swm_pkg::ELEM_W-1:0] a_mat[64];
   logic signed [swm_pkg::ELEM_W-1:0] b_mat[64];

   int  fail_count;
   int  cycle_count;
   bit  req_taken;
   bit  send_hold;
   bit  long_hold_req;
   bit  long_hold_done;
   int  hold_count;
   int  gap_left;
   int  stall_left;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Load one pair into the predictor; emit the whole product on the last pair.
   task automatic load_pair(input swm_pkg::req_type pair);
      int m, n;
      longint acc;
      swm_pkg::rsp_type elem;
      m = (half_reg < 1) ? 1 : (half_reg > HALF_MAX) ? HALF_MAX : int'(half_reg);
      n = 2 * m;
      a_mat[pairs_loaded] = pair.a_value;
      b_mat[pairs_loaded] = pair.b_value;
      pairs_loaded++;
      if (pairs_loaded == n * n) begin
         pairs_loaded = 0;
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               acc = 0;
               for (int k = 0; k < n; k++)
                  acc += longint'(a_mat[r*n+k]) * longint'(b_mat[k*n+c]);
               elem.c_value      = acc[swm_pkg::C_W-1:0];
               elem.last_element = (r == n - 1) && (c == n - 1);
               expected_elems = {expected_elems, elem};
            end
         end
      end
   endtask

   // Sample both channels and the register port at the rising edge.
   always @(posedge clock) begin
      swm_pkg::rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         req_taken = 1'b0;
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               if (expected_elems.size() == 0) begin
                  $display("%0t: unexpected element c=%0d last=%0b", $time,
                           rsp_data.c_value, rsp_data.last_element);
                  fail_count++;
               end else begin
                  want = expected_elems.pop_front();
                  if (want.c_value !== rsp_data.c_value) begin
                     $display("%0t: c_value expected %0d actual %0d", $time,
                              want.c_value, rsp_data.c_value);
                     fail_count++;
                  end
                  if (want.last_element !== rsp_data.last_element) begin
                     $display("%0t: last_element expected %0b actual %0b", $time,
                              want.last_element, rsp_data.last_element);
                     fail_count++;
                  end
               end
            end
            if (csr_we) begin
               half_reg     = csr_wdata;
               pairs_loaded = 0;
            end
            if (req_valid && !req_stall) begin
               req_taken = 1'b1;
               load_pair(req_data);
            end
         end
      end
   end

   // Drive the input channel from the pending queue with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0 && !send_hold) begin
            req_data  <= pending_pairs.pop_front();
            req_valid <= 1'b1;
            case ($urandom_range(9))
               0:       gap_left = $urandom_range(40, 10);
               1, 2, 3: gap_left = $urandom_range(3, 1);
               default: gap_left = 0;
            endcase
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel: random short and long stretches, one long hold.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_stall <= 1'b1;
         hold_count++;
         if (hold_count == LONG_HOLD) long_hold_done = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         case ($urandom_range(19))
            0:             stall_left = $urandom_range(40, 10);
            1, 2, 3, 4, 5: stall_left = $urandom_range(3, 1);
            default:       stall_left = 0;
         endcase
         rsp_stall <= (stall_left > 0);
      end
   end

   // Wait until nothing is queued, in flight or expected.
   task automatic drain;
      wait (pending_pairs.size() == 0 && !req_valid && expected_elems.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_half(input logic [2:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic signed [swm_pkg::ELEM_W-1:0] pick_elem(input bit extreme);
      if (extreme) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      return 16'($urandom);
   endfunction

   // Queue one full matrix pair for the given register value.
   task automatic queue_matrix(input logic [2:0] value, input bit extremes);
      int m;
      swm_pkg::req_type pair;
      m = (value < 1) ? 1 : (value > HALF_MAX) ? HALF_MAX : int'(value);
      for (int i = 0; i < 4 * m * m; i++) begin
         pair.a_value = pick_elem(extremes && ($urandom_range(1) == 1));
         pair.b_value = pick_elem(extremes && ($urandom_range(1) == 1));
         pending_pairs = {pending_pairs, pair};
      end
   endtask

   initial begin
      int sent;
      int m;
      bit first_phase;
      logic [2:0] value;
      swm_pkg::req_type pair;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      fail_count     = 0;
      cycle_count    = 0;
      send_hold      = 1'b0;
      long_hold_req  = 1'b0;
      long_hold_done = 1'b0;
      hold_count     = 0;
      gap_left       = 0;
      stall_left     = 0;
      half_reg       = 3'd4;
      pairs_loaded   = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // half size zero clamps to one: all-max and all-min matrices
      write_half(3'd0);
      repeat (4) begin
         pair.a_value = 16'sh7fff;
         pair.b_value = 16'sh7fff;
         pending_pairs = {pending_pairs, pair};
      end
      repeat (4) begin
         pair.a_value = 16'sh8000;
         pair.b_value = 16'sh8000;
         pending_pairs = {pending_pairs, pair};
      end
      drain();

      // partial load at half size two, discarded by a register write
      write_half(3'd2);
      repeat (5) begin
         pair.a_value = pick_elem(1'b0);
         pair.b_value = pick_elem(1'b0);
         pending_pairs = {pending_pairs, pair};
      end
      drain();
      write_half(3'd2);
      queue_matrix(3'd2, 1'b1);
      drain();

      // half size above the maximum saturates; hold results long to fill up
      write_half(3'd7);
      long_hold_req = 1'b1;
      queue_matrix(3'd7, 1'b0);
      queue_matrix(3'd7, 1'b1);
      drain();

      // random phases over all register values
      sent = 0;
      while (sent < RAND_ITEMS) begin
         first_phase = (sent == 0);
         value = 3'($urandom_range(7));
         m = (value < 1) ? 1 : (value > HALF_MAX) ? HALF_MAX : int'(value);
         write_half(value);
         queue_matrix(value, $urandom_range(4) == 0);
         sent += 4 * m * m;
         if (first_phase) begin
            queue_matrix(value, 1'b0);
            sent += 4 * m * m;
         end
         // pause the sender until all results are back, always the first time
         if (first_phase || $urandom_range(3) == 0) begin
            wait (expected_elems.size() != 0);
            send_hold = 1'b1;
            wait (expected_elems.size() == 0);
            repeat (20) @(posedge clock);
            send_hold = 1'b0;
         end
         drain();
      end

      write_half(3'd1);
      queue_matrix(3'd1, 1'b1);
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_elems.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
